// ----- sv/stee_pkg.sv -----
// Package for the software timer expiry engine: constants, request and result types,
// controller states and the controller-to-datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps
package stee_pkg;
  localparam int NumTimers = 8;
  localparam int TickBits = 32;
  localparam int IdxBits = 3;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_TICK  = 2'd0;
  localparam mode_t MODE_START = 2'd1;
  localparam mode_t MODE_STOP  = 2'd2;

  typedef struct packed {
    logic [1:0]          mode;
    logic [IdxBits-1:0]  timer_index;
    logic [31:0]         period;
    logic                periodic;
  } req_t;

  typedef struct packed {
    logic [IdxBits-1:0] fired_index;
    logic               last;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRAP_PICK,
    ST_WRAP_FIRE,
    ST_SWAP,
    ST_DUE_PICK,
    ST_DUE_FIRE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic pick;
    logic pick_due;
    logic fire_wrap;
    logic fire_due;
    logic swap;
    logic advance;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic wraps;
    logic found;
  } stat_t;
endpackage

// ----- sv/software_timer_expiry_engine.sv -----
// Top level of the software timer expiry engine: joins controller and datapath.
// Depends on stee_pkg, stee_ctrl and stee_dp.
`timescale 1ns / 1ps
// A start or stop request keeps busy high for one cycle; no new request is taken until
// busy falls. A tick keeps busy high through the done, swap, due pick and due fire states,
// repeating pick and fire per expiring timer, plus wrap pick and fire per flushed timer
// at a counter wrap. One timer is chosen per pass of the selection logic. Each expiry
// appears for one cycle with done high and is not held: the receiver must take it then.
// Each result waits for the next fire or the tick's end; the last appears as busy falls.
module software_timer_expiry_engine
  import stee_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  output logic busy,
  output logic done,
  output res_t result
);
  cmd_t  cmd;
  stat_t stat;

  stee_ctrl u_ctrl (.clk, .rst, .start, .stat, .cmd, .busy);
  stee_dp   u_dp (.clk, .rst, .req, .cmd, .stat, .done, .result);
endmodule

// ----- sv/stee_ctrl.sv -----
// Controller state machine for the software timer expiry engine.
// Depends on stee_pkg.
`timescale 1ns / 1ps
module stee_ctrl
  import stee_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!stat.is_tick) state_next = ST_IDLE;
        else if (stat.wraps) state_next = ST_WRAP_PICK;
        else state_next = ST_SWAP;
      end
      ST_WRAP_PICK: state_next = ST_WRAP_FIRE;
      ST_WRAP_FIRE: state_next = stat.found ? ST_WRAP_PICK : ST_SWAP;
      ST_SWAP: state_next = ST_DUE_PICK;
      ST_DUE_PICK: state_next = ST_DUE_FIRE;
      ST_DUE_FIRE: state_next = stat.found ? ST_DUE_PICK : ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        cmd.load = start;
      end
      ST_DONE: ;
      ST_WRAP_PICK: cmd.pick = 1'b1;
      ST_WRAP_FIRE: cmd.fire_wrap = 1'b1;
      ST_SWAP: begin
        cmd.swap = stat.wraps;
        cmd.advance = 1'b1;
      end
      ST_DUE_PICK: begin
        cmd.pick = 1'b1;
        cmd.pick_due = 1'b1;
      end
      ST_DUE_FIRE: begin
        cmd.fire_due = 1'b1;
        cmd.finish = !stat.found;
      end
      default: ;
    endcase
  end
endmodule

// ----- sv/stee_dp.sv -----
// Datapath of the software timer expiry engine: timer bank, selection and re-arm logic.
// Depends on stee_pkg.
`timescale 1ns / 1ps
module stee_dp
  import stee_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  req_t  req,
  input  cmd_t  cmd,
  output stat_t stat,
  output logic  done,
  output res_t  result
);
  logic [TickBits-1:0] tick_now;
  logic [TickBits-1:0] expiry_time [NumTimers];
  logic [TickBits-1:0] period_store [NumTimers];
  logic [NumTimers-1:0] reload_flag, armed, ovf, fired, rearm_old;
  req_t r;
  logic [IdxBits-1:0] sel;
  logic found, pend;
  logic [IdxBits-1:0] pend_idx;
  logic [TickBits-1:0] nxt;

  logic [IdxBits-1:0] best;
  logic best_ok;
  logic [TickBits-1:0] best_e;

  assign nxt = tick_now + 1'b1;

  always_comb begin
    best = '0;
    best_ok = 1'b0;
    best_e = '0;
    for (int t = 0; t < NumTimers; t++) begin
      if (armed[t] && !ovf[t] && !fired[t] &&
          !(cmd.pick_due && expiry_time[t] > tick_now) &&
          (!best_ok || expiry_time[t] < best_e)) begin
        best = IdxBits'(t);
        best_ok = 1'b1;
        best_e = expiry_time[t];
      end
    end
  end

  assign stat.is_tick = r.mode == MODE_TICK;
  assign stat.wraps = nxt == '0;
  assign stat.found = found;

  logic [TickBits-1:0] e_s, p_s, rl, nowp;
  assign e_s = expiry_time[sel];
  assign p_s = period_store[sel];
  assign rl = e_s + p_s;
  assign nowp = tick_now + p_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_now <= '0;
      reload_flag <= '0;
      armed <= '0;
      ovf <= '0;
      fired <= '0;
      rearm_old <= '0;
      found <= 1'b0;
      pend <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.load) begin
        r <= req;
        fired <= '0;
        rearm_old <= '0;
        if (req.mode == MODE_START) begin
          period_store[req.timer_index] <= (req.period == '0) ? 32'd1 : req.period;
          reload_flag[req.timer_index] <= req.periodic;
          expiry_time[req.timer_index] <= tick_now +
            ((req.period == '0) ? 32'd1 : req.period);
          ovf[req.timer_index] <= (tick_now +
            ((req.period == '0) ? 32'd1 : req.period)) < tick_now;
          armed[req.timer_index] <= 1'b1;
        end else if (req.mode == MODE_STOP) begin
          armed[req.timer_index] <= 1'b0;
        end
      end
      if (cmd.pick) begin
        sel <= best;
        found <= best_ok;
      end
      if ((cmd.fire_wrap || cmd.fire_due) && found) begin
        fired[sel] <= 1'b1;
        if (pend) begin
          done <= 1'b1;
          result.fired_index <= pend_idx;
          result.last <= 1'b0;
        end
        pend <= 1'b1;
        pend_idx <= sel;
        if (!reload_flag[sel]) armed[sel] <= 1'b0;
        else if (cmd.fire_wrap) begin
          if (rl > e_s || rl == '0) rearm_old[sel] <= 1'b1;
          else expiry_time[sel] <= rl;
        end else if (rl <= tick_now) begin
          if ((tick_now - e_s) >= p_s) begin
            expiry_time[sel] <= nowp;
            ovf[sel] <= nowp < tick_now;
          end else begin
            expiry_time[sel] <= rl;
            ovf[sel] <= 1'b1;
          end
        end else begin
          expiry_time[sel] <= rl;
          ovf[sel] <= 1'b0;
        end
      end
      if (cmd.advance) begin
        tick_now <= nxt;
        if (cmd.swap) begin
          for (int t = 0; t < NumTimers; t++) begin
            ovf[t] <= 1'b0;
            if (rearm_old[t]) expiry_time[t] <= period_store[t];
          end
        end
      end
      if (cmd.finish && pend) begin
        done <= 1'b1;
        result.fired_index <= pend_idx;
        result.last <= 1'b1;
        pend <= 1'b0;
      end
    end
  end
endmodule

// ----- sv/stee_checker.sv -----
// Port-level checks for the software timer expiry engine, bound to the top level.
// Depends on stee_pkg.
`timescale 1ns / 1ps
module stee_checker
  import stee_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input res_t result
);
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised");
  a_done_when_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without a request in progress");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    done && result.last |=> !done) else $error("result after last");
endmodule

bind software_timer_expiry_engine stee_checker u_chk (.clk, .rst, .start, .busy, .done,
  .result);
